[hdl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, types and helper functions of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_POOL_ORDER_DEF = 14;
    localparam int HEADER_BYTES_DEF   = 32;

    localparam logic [3:0] RESET_POOL_ORDER = 4'd14;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_FREE      = 2'd2;
    localparam logic [1:0] ST_NOT_BLOCK = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Entry layout: head bit, used bit, five order bits.
    typedef struct packed {
        logic       head;
        logic       used;
        logic [4:0] ord;
    } entry_t;

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT,
        S_GRANT,
        S_FREE_RD,
        S_FREE_CHK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_RESULT
    } state_t;

    // Unit size follows the header size.
    function automatic int unit_order_f(input int hdr);
        if (hdr > 32)      return 6;
        else if (hdr > 16) return 5;
        else if (hdr > 8)  return 4;
        else               return 3;
    endfunction

endpackage

[hdl/buddy_block_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator keeping its block table in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the slave stream is one request: an allocate (opcode 0) of
// request_bytes payload bytes, or a free (opcode 1) of a payload offset
// returned earlier. Each request yields exactly one word on the master
// stream: status, payload offset, order and the free byte count left.
// The cfg channel writes pool_order; any write re-initialises the pool,
// which sweeps the block table clear, one entry a cycle, over all table
// entries. The same sweep follows reset, during which s_tready stays low.
// Requests are handled one at a time by a sequencer around the table
// memory, whose reads are registered. An allocate reads each block
// visited by the address-order search (up to two full passes over the
// pool) and then halves the found block step by step; a free checks
// its block and then merges it with its buddy step by step, writing the
// merged head in the result state when it merges back into the whole pool.
// The result sits in an output register; the next request is accepted as
// soon as the previous one is finished, even while the result waits.
// A stalled master side holds the result and holds the next request in S_RESULT.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
    parameter int MAX_POOL_ORDER = bba_pkg::MAX_POOL_ORDER_DEF,
    parameter int HEADER_BYTES   = bba_pkg::HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode [0], request_bytes [14:1], release_offset [28:15], zero fill
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status [1:0], payload_offset [15:2], granted_order [19:16],
    // bytes_free [34:20], zero fill
    output logic [39:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    import bba_pkg::*;

    localparam int UO    = unit_order_f(HEADER_BYTES);
    localparam int UBITS = MAX_POOL_ORDER - UO;
    localparam int UNITS = 1 << UBITS;
    localparam int FBW   = MAX_POOL_ORDER + 1;
    localparam int TW    = 32; // wide scratch for order sizes and sums

    // Block table memory.
    entry_t mem [UNITS];
    logic [UBITS-1:0] rd_addr, wr_addr;
    logic             wr_en;
    entry_t           wr_data, rd_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    // Registers.
    state_t           state_reg, state_next;
    logic [4:0]       pord_reg, pord_next;
    logic [UBITS-1:0] rover_reg, rover_next;
    logic [FBW-1:0]   free_reg, free_next;
    logic [UBITS:0]   clr_reg, clr_next;
    logic             pinit_reg, pinit_next;
    logic [UBITS-1:0] cur_reg, cur_next;       // unit being looked at
    logic [UBITS-1:0] s_reg, s_next;           // block start
    logic [4:0]       k_reg, k_next;           // wanted / current order
    logic [4:0]       o_reg, o_next;           // split order
    logic             pass_reg, pass_next;     // 0 exact, 1 larger
    logic [UBITS:0]   cnt_reg, cnt_next;
    logic [1:0]       rst_reg, rst_next;
    logic [13:0]      pay_reg, pay_next;
    logic [3:0]       gord_reg, gord_next;
    logic             mv_reg, mv_next;
    logic [39:0]      mdata_reg, mdata_next;

    // Input fields.
    logic        in_op;
    logic [13:0] in_req, in_rel;
    assign in_op  = s_tdata[0];
    assign in_req = s_tdata[14:1];
    assign in_rel = s_tdata[28:15];

    // Clamp of the written order.
    logic [4:0] cfg_ord;
    always_comb
    begin
        cfg_ord = {1'b0, cfg_data};
        if (cfg_ord > 5'(MAX_POOL_ORDER)) cfg_ord = 5'(MAX_POOL_ORDER);
        if (cfg_ord < 5'(UO + 1))         cfg_ord = 5'(UO + 1);
    end

    logic [4:0] rst_ord;
    always_comb
    begin
        rst_ord = {1'b0, RESET_POOL_ORDER};
        if (rst_ord > 5'(MAX_POOL_ORDER)) rst_ord = 5'(MAX_POOL_ORDER);
        if (rst_ord < 5'(UO + 1))         rst_ord = 5'(UO + 1);
    end

    // Units in the pool, and size of a request.
    logic [UBITS:0] punits;
    assign punits = (UBITS+1)'(1) << (pord_reg - 5'(UO));

    logic [TW-1:0] total;
    logic [4:0]    kreq;
    always_comb
    begin
        total = TW'(HEADER_BYTES) + TW'(in_req);
        kreq  = 5'd0;
        for (int i = 30; i >= 0; i--)
        begin
            if ((TW'(1) << i) >= total) kreq = 5'(i);
        end
    end

    // Step from a unit to the next block, given its entry.
    function automatic logic [UBITS-1:0] step_f(input logic [UBITS-1:0] u,
                                                input entry_t e,
                                                input logic [UBITS:0] pu);
        logic [UBITS+1:0] n;
        n = {2'b0, u} + 1'b1;
        if (e.ord >= 5'(UO) && e.ord <= 5'(MAX_POOL_ORDER))
        begin
            n = {2'b0, u} + ((UBITS+2)'(1) << (e.ord - 5'(UO)));
        end
        return (n >= {1'b0, pu}) ? '0 : n[UBITS-1:0];
    endfunction

    function automatic logic [UBITS-1:0] buddy_of(input logic [UBITS-1:0] s,
                                                  input logic [4:0] o);
        logic [UBITS:0] b;
        b = {1'b0, s} ^ ((UBITS+1)'(1) << (o - 5'(UO)));
        return b[UBITS-1:0];
    endfunction

    // Free address decode.
    logic [13:0] fstart;
    assign fstart = in_rel - 14'(HEADER_BYTES);

    logic [UBITS-1:0] buddy;
    logic [UBITS:0]   buddy_w;
    assign buddy_w = {1'b0, s_reg} ^ ((UBITS+1)'(1) << (k_reg - 5'(UO)));
    assign buddy   = buddy_w[UBITS-1:0];

    logic [UBITS:0] half_w;
    assign half_w = {1'b0, s_reg} + ((UBITS+1)'(1) << (o_reg - 5'd1 - 5'(UO)));

    logic match;
    always_comb
    begin
        if (!pass_reg) match = rd_data.head && !rd_data.used && rd_data.ord == k_reg;
        else           match = rd_data.head && !rd_data.used && rd_data.ord > k_reg;
    end

    logic [TW-1:0] ksize;
    assign ksize = TW'(1) << k_reg;

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_INIT_CLR);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = mdata_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT_CLR:
                if (clr_reg == (UBITS+1)'(UNITS - 1) && !cfg_valid) state_next = S_IDLE;
            S_IDLE:
                if (cfg_valid) state_next = S_INIT_CLR;
                else if (s_tvalid)
                begin
                    if (in_op == OP_FREE)
                    begin
                        if (fstart[UO-1:0] != '0 ||
                            TW'(fstart[13:UO]) >= TW'(punits))
                            state_next = S_RESULT;
                        else state_next = S_FREE_RD;
                    end
                    else if (kreq <= 5'(MAX_POOL_ORDER) &&
                             (TW'(1) << kreq) < TW'(free_reg))
                        state_next = S_SCAN_RD;
                    else state_next = S_RESULT;
                end
            S_SCAN_RD:   state_next = S_SCAN_CHK;
            S_SCAN_CHK:
                if (match) state_next = (rd_data.ord > k_reg) ? S_SPLIT : S_GRANT;
                else if (cur_reg == rover_reg || cnt_reg == (UBITS+1)'(UNITS - 1))
                    state_next = pass_reg ? S_RESULT : S_SCAN_RD;
                else state_next = S_SCAN_RD;
            S_SPLIT:     if (o_reg - 5'd1 == k_reg) state_next = S_GRANT;
            S_GRANT:     state_next = S_RESULT;
            S_FREE_RD:   state_next = S_FREE_CHK;
            S_FREE_CHK:
                if (!rd_data.head || !rd_data.used ||
                    rd_data.ord >= pord_reg) state_next = S_RESULT;
                else state_next = S_MERGE_RD;
            S_MERGE_RD:  state_next = S_MERGE_CHK;
            S_MERGE_CHK:
                if (rd_data == entry_t'{1'b1, 1'b0, k_reg} && {1'b0, buddy} < punits &&
                    k_reg + 5'd1 < pord_reg) state_next = S_MERGE_RD;
                else state_next = S_RESULT;
            // A pending merged head write keeps the result back.
            S_RESULT:
                if ((!mv_reg || m_tready) && !(o_reg == 5'd1 && rst_reg == ST_OK))
                    state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        pord_next = pord_reg; rover_next = rover_reg; free_next = free_reg;
        clr_next = clr_reg; pinit_next = pinit_reg; cur_next = cur_reg;
        s_next = s_reg; k_next = k_reg; o_next = o_reg; pass_next = pass_reg;
        cnt_next = cnt_reg; rst_next = rst_reg; pay_next = pay_reg;
        gord_next = gord_reg; mv_next = mv_reg; mdata_next = mdata_reg;
        rd_addr = cur_reg; wr_en = 1'b0; wr_addr = '0; wr_data = '0;
        if (mv_reg && m_tready) mv_next = 1'b0;
        unique case (state_reg)
            S_INIT_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg[UBITS-1:0];
                wr_data = (clr_reg == '0) ? entry_t'{1'b1, 1'b0, pord_reg} : '0;
                clr_next = clr_reg + 1'b1;
                if (cfg_valid)
                begin
                    pord_next = cfg_ord; clr_next = '0; pinit_next = 1'b1;
                    free_next = FBW'(1) << cfg_ord; rover_next = '0;
                end
                else if (!pinit_reg)
                begin
                    pinit_next = 1'b1; pord_next = rst_ord;
                    free_next = FBW'(1) << rst_ord; clr_next = '0;
                end
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    pord_next = cfg_ord; clr_next = '0; pinit_next = 1'b1;
                    free_next = FBW'(1) << cfg_ord; rover_next = '0;
                end
                else if (s_tvalid)
                begin
                    rst_next = ST_NO_SPACE; pay_next = '0; gord_next = '0;
                    k_next = kreq; pass_next = 1'b0; cnt_next = '0;
                    cur_next = rover_reg;
                    rd_addr = rover_reg;
                    if (in_op == OP_FREE)
                    begin
                        rst_next = ST_NOT_BLOCK;
                        s_next   = UBITS'(fstart[13:UO]);
                        rd_addr  = UBITS'(fstart[13:UO]);
                    end
                end
            end
            S_SCAN_RD:
            begin
                // rd_data holds the entry at cur_reg; advance.
                cur_next = step_f(cur_reg, rd_data, punits);
                rd_addr  = step_f(cur_reg, rd_data, punits);
                cnt_next = cnt_reg + 1'b1;
            end
            S_SCAN_CHK:
            begin
                rd_addr = cur_reg;
                if (match)
                begin
                    s_next = cur_reg; o_next = rd_data.ord;
                end
                else if (cur_reg == rover_reg || cnt_reg == (UBITS+1)'(UNITS - 1))
                begin
                    pass_next = 1'b1; cnt_next = '0; cur_next = rover_reg;
                    rd_addr = rover_reg;
                end
            end
            S_SPLIT:
            begin
                wr_en   = 1'b1;
                wr_addr = half_w[UBITS-1:0];
                wr_data = entry_t'{1'b1, 1'b0, o_reg - 5'd1};
                o_next  = o_reg - 5'd1;
            end
            S_GRANT:
            begin
                wr_en   = 1'b1;
                wr_addr = s_reg;
                wr_data = entry_t'{1'b1, 1'b1, k_reg};
                free_next  = free_reg - FBW'(ksize);
                rover_next = s_reg;
                rst_next   = ST_OK;
                pay_next   = 14'((TW'(s_reg) << UO) + TW'(HEADER_BYTES));
                gord_next  = 4'(k_reg);
            end
            S_FREE_RD: rd_addr = s_reg;
            S_FREE_CHK:
            begin
                rd_addr = buddy_of(s_reg, rd_data.ord);
                if (rd_data.head)
                begin
                    if (!rd_data.used) rst_next = ST_FREE;
                    else
                    begin
                        rst_next  = ST_OK;
                        k_next    = rd_data.ord;
                        gord_next = 4'(rd_data.ord);
                        free_next = free_reg + (FBW'(1) << rd_data.ord);
                        wr_en = 1'b1; wr_addr = s_reg;
                        wr_data = entry_t'{1'b1, 1'b0, rd_data.ord};
                        rover_next = s_reg;
                    end
                end
            end
            S_MERGE_RD: rd_addr = buddy;
            S_MERGE_CHK:
            begin
                if (rd_data == entry_t'{1'b1, 1'b0, k_reg} && {1'b0, buddy} < punits)
                begin
                    // clear upper header now; head of merged block written next
                    wr_en = 1'b1;
                    wr_addr = (s_reg > buddy) ? s_reg : buddy;
                    wr_data = '0;
                    s_next  = (s_reg < buddy) ? s_reg : buddy;
                    k_next  = k_reg + 5'd1;
                    rover_next = (s_reg < buddy) ? s_reg : buddy;
                    o_next = 5'd1; // marks a pending head write
                end
                else o_next = 5'd0;
            end
            S_RESULT:
            begin
                if (o_reg == 5'd1 && rst_reg == ST_OK)
                begin
                    wr_en = 1'b1; wr_addr = s_reg;
                    wr_data = entry_t'{1'b1, 1'b0, k_reg};
                    o_next = 5'd0;
                end
                if ((!mv_reg || m_tready) && !(o_reg == 5'd1 && rst_reg == ST_OK))
                begin
                    mv_next = 1'b1;
                    mdata_next = {5'b0, free_reg, gord_reg, pay_reg, rst_reg};
                end
            end
            default: ;
        endcase
        // Merged head write: issued in the cycle after the clear, on re-read.
        if (state_reg == S_MERGE_RD && o_reg == 5'd1)
        begin
            wr_en = 1'b1; wr_addr = s_reg;
            wr_data = entry_t'{1'b1, 1'b0, k_reg};
            o_next = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR; pord_reg <= 5'd0; rover_reg <= '0;
            free_reg <= '0; clr_reg <= '0; pinit_reg <= 1'b0; mv_reg <= 1'b0;
            o_reg <= '0; k_reg <= '0; pass_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next; pord_reg <= pord_next; rover_reg <= rover_next;
            free_reg <= free_next; clr_reg <= clr_next; pinit_reg <= pinit_next;
            mv_reg <= mv_next; o_reg <= o_next; k_reg <= k_next;
            pass_reg <= pass_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next; s_reg <= s_next; rst_reg <= rst_next;
        pay_reg <= pay_next; gord_reg <= gord_next; mdata_reg <= mdata_next;
    end

    // A result only appears after a finished operation.
    a_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == S_RESULT)
        else $error("result without operation");
    // Free bytes never exceed the pool.
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        pinit_reg |-> free_reg <= (FBW'(1) << pord_reg))
        else $error("free count beyond pool");
    // No request is taken while a pool sweep runs.
    a_clr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INIT_CLR |-> !s_tready)
        else $error("request during sweep");

endmodule
